[hdl/rar_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and constants of the rice-pile avalanche block
// no dependencies

package rar_pkg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] site_index;
    } t_in_req;

    typedef struct packed {
        logic [9:0]  pile_height;
        logic [23:0] avalanche_size;
        logic [31:0] crossover_drive;
        logic        crossover_seen;
        logic [2:0]  slope_value;
    } t_out_req;

    localparam logic [1:0] OP_DRIVE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [1:0] REG_ACTIVE_SITES = 2'd0;
    localparam logic [1:0] REG_THRESH_PROB  = 2'd1;
    localparam logic [1:0] REG_SEED         = 2'd2;

    localparam int ADDR_W = 4;

    localparam int          LIST_AW    = 7;
    localparam logic [7:0]  LIST_DEPTH = 8'd128;
    localparam logic [9:0]  HEIGHT_MAX = 10'd1023;
    localparam logic [23:0] AVAL_MAX   = 24'hFFFFFF;
    localparam logic [2:0]  SLOPE_MAX  = 3'd7;
    localparam logic [16:0] PROB_MAX   = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_READ,
        ST_D_WR,
        ST_GEN,
        ST_L_RD,
        ST_P_RD,
        ST_P_WR,
        ST_N_RD,
        ST_N_WR,
        ST_DRV_END,
        ST_DONE
    } t_state;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

[hdl/ricepile_avalanche_relax.sv]
`timescale 1ns / 1ps
// rice-pile avalanche relaxation block: site store, generation lists and sequencer
// depends on rar_pkg
//
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data) takes one request:
//   drive a grain at site 0 and relax, read one slope, or initialise the pile.
//   every request gives one result on o_out_valid / i_out_stall / o_out_data.
//   a single read/modify/write sequencer over the site memory does all work,
//   one memory access per cycle, so one request is in flight at a time.
//   a read passes the READ state; an init writes each active site in turn;
//   a drive writes site 0, then per generation swaps lists and, per listed site,
//   reads list and site, then writes a toppled site and each of its neighbors.
//   the result sits in an output register; while the receiver stalls it holds
//   and the next request is already accepted and worked on.
//   the user writes configuration over the apb port only while the block is idle;
//   the block does not enforce it. reset clears all slopes, counters and the
//   generator (state one); thresholds are undefined until the first init request.

module ricepile_avalanche_relax #(
    parameter int MAX_SITES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rar_pkg::t_in_req              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rar_pkg::t_out_req             o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rar_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rar_pkg::*;

    localparam int SW  = $clog2(MAX_SITES);
    localparam int CW0 = $clog2(MAX_SITES + 1);
    localparam int LW  = (CW0 > 7) ? CW0 : 7;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_SITES);
    localparam logic [LW-1:0] MIN_LEN = LW'(2);

    // configuration
    logic [6:0]  r_active_sites;
    logic [16:0] r_prob;
    logic [31:0] r_seed;
    logic [1:0]  w_cfg_idx;
    logic        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_sites <= 7'd64;
            r_prob         <= 17'd32768;
            r_seed         <= 32'd1;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_ACTIVE_SITES: r_active_sites <= pwdata[6:0];
                REG_THRESH_PROB:  r_prob         <= pwdata[16:0];
                REG_SEED:         r_seed         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_ACTIVE_SITES: prdata = {25'd0, r_active_sites};
            REG_THRESH_PROB:  prdata = {15'd0, r_prob};
            REG_SEED:         prdata = r_seed;
            default:          prdata = 32'd0;
        endcase
    end

    // state
    t_state          r_state, n_state;
    logic            r_bank, n_bank;
    logic [SW-1:0]   r_p, n_p;
    logic [SW-1:0]   r_nb, n_nb;
    logic            r_two, n_two;
    logic [7:0]      r_i, n_i;
    logic [7:0]      r_cur_cnt, n_cur_cnt;
    logic [7:0]      r_nxt_cnt, n_nxt_cnt;
    logic [SW-1:0]   r_idx, n_idx;
    logic [9:0]      r_height, n_height;
    logic [31:0]     r_drive, n_drive;
    logic [31:0]     r_cross, n_cross;
    logic            r_flag, n_flag;
    logic [23:0]     r_aval, n_aval;
    logic [31:0]     r_rng, n_rng;
    logic [2:0]      r_slope_out, n_slope_out;
    logic            r_out_valid, n_out_valid;
    t_out_req        r_out_data, n_out_data;

    // memories
    logic [3:0]           mem_site [MAX_SITES];
    logic [MAX_SITES-1:0] r_valid;
    logic [3:0]           r_mem_rd;
    logic                 r_mem_rvalid;
    logic [SW-1:0]        list0 [128];
    logic [SW-1:0]        list1 [128];
    logic [SW-1:0]        r_l0_rd, r_l1_rd;

    logic                 w_mem_we;
    logic [SW-1:0]        w_mem_waddr, w_mem_raddr;
    logic [3:0]           w_mem_wdata;
    logic                 w_clr_valid;
    logic                 w_list_we;
    logic [LIST_AW-1:0]   w_list_waddr, w_list_raddr;
    logic [SW-1:0]        w_list_wdata;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_site[w_mem_waddr] <= w_mem_wdata;
        end
        r_mem_rd     <= mem_site[w_mem_raddr];
        r_mem_rvalid <= r_valid[w_mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_clr_valid) begin
            r_valid <= '0;
        end else if (w_mem_we) begin
            r_valid[w_mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_list_we && r_bank) begin
            list0[w_list_waddr] <= w_list_wdata;
        end
        if (w_list_we && !r_bank) begin
            list1[w_list_waddr] <= w_list_wdata;
        end
        r_l0_rd <= list0[w_list_raddr];
        r_l1_rd <= list1[w_list_raddr];
    end

    // derived values
    logic [LW-1:0] w_act, w_len, w_last;
    logic [16:0]   w_prob;
    logic [31:0]   w_rng_next;
    logic          w_draw;
    logic [2:0]    w_rslope;
    logic          w_rthr;
    logic [3:0]    w_thr_val;
    logic [2:0]    w_inc;
    logic [SW-1:0] w_lp;
    logic          w_p_last;
    logic [2:0]    w_new_s;
    logic [LW-1:0] w_site_ext;

    assign w_act      = LW'(r_active_sites);
    assign w_len      = (w_act < MIN_LEN) ? MIN_LEN : ((w_act > MAX_LEN) ? MAX_LEN : w_act);
    assign w_last     = w_len - LW'(1);
    assign w_prob     = (r_prob > PROB_MAX) ? PROB_MAX : r_prob;
    assign w_rng_next = xorshift32(r_rng);
    assign w_draw     = ({1'b0, w_rng_next[31:16]} < w_prob) ? 1'b0 : 1'b1;
    assign w_rslope   = r_mem_rvalid ? r_mem_rd[2:0] : 3'd0;
    assign w_rthr     = r_mem_rd[3];
    assign w_thr_val  = {3'd0, w_rthr} + 4'd1;
    assign w_inc      = (w_rslope == SLOPE_MAX) ? SLOPE_MAX : w_rslope + 3'd1;
    assign w_lp       = r_bank ? r_l1_rd : r_l0_rd;
    assign w_p_last   = (LW'(r_p) == w_last);
    assign w_new_s    = w_p_last ? (w_rslope - 3'd1) : (w_rslope - 3'd2);
    assign w_site_ext = LW'(i_in_data.site_index);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_i         <= 8'd0;
            r_cur_cnt   <= 8'd0;
            r_nxt_cnt   <= 8'd0;
            r_height    <= 10'd0;
            r_drive     <= 32'd0;
            r_cross     <= 32'd0;
            r_flag      <= 1'b0;
            r_aval      <= 24'd0;
            r_rng       <= 32'd1;
            r_slope_out <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_i         <= n_i;
            r_cur_cnt   <= n_cur_cnt;
            r_nxt_cnt   <= n_nxt_cnt;
            r_height    <= n_height;
            r_drive     <= n_drive;
            r_cross     <= n_cross;
            r_flag      <= n_flag;
            r_aval      <= n_aval;
            r_rng       <= n_rng;
            r_slope_out <= n_slope_out;
            r_out_valid <= n_out_valid;
        end
        r_p        <= n_p;
        r_nb       <= n_nb;
        r_two      <= n_two;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_p          = r_p;
        n_nb         = r_nb;
        n_two        = r_two;
        n_i          = r_i;
        n_cur_cnt    = r_cur_cnt;
        n_nxt_cnt    = r_nxt_cnt;
        n_idx        = r_idx;
        n_height     = r_height;
        n_drive      = r_drive;
        n_cross      = r_cross;
        n_flag       = r_flag;
        n_aval       = r_aval;
        n_rng        = r_rng;
        n_slope_out  = r_slope_out;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        w_mem_we     = 1'b0;
        w_mem_waddr  = '0;
        w_mem_wdata  = 4'd0;
        w_mem_raddr  = '0;
        w_clr_valid  = 1'b0;
        w_list_we    = 1'b0;
        w_list_waddr = r_nxt_cnt[LIST_AW-1:0];
        w_list_wdata = '0;
        w_list_raddr = r_i[LIST_AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                n_nxt_cnt = 8'd0;
                if (i_in_valid) begin
                    n_slope_out = 3'd0;
                    priority if (i_in_data.opcode == OP_DRIVE) begin
                        w_mem_raddr = '0;
                        n_state     = ST_D_WR;
                    end else if (i_in_data.opcode == OP_READ) begin
                        if (w_site_ext < w_len) begin
                            w_mem_raddr = w_site_ext[SW-1:0];
                            n_state     = ST_READ;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else if (i_in_data.opcode == OP_INIT) begin
                        w_clr_valid = 1'b1;
                        n_height    = 10'd0;
                        n_drive     = 32'd0;
                        n_cross     = 32'd0;
                        n_flag      = 1'b0;
                        n_aval      = 24'd0;
                        n_rng       = (r_seed == 32'd0) ? 32'd1 : r_seed;
                        n_idx       = '0;
                        n_state     = ST_INIT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INIT: begin
                n_rng       = w_rng_next;
                w_mem_we    = 1'b1;
                w_mem_waddr = r_idx;
                w_mem_wdata = {w_draw, 3'd0};
                n_idx       = r_idx + SW'(1);
                if (LW'(r_idx) == w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_slope_out = w_rslope;
                n_state     = ST_DONE;
            end
            ST_D_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = '0;
                w_mem_wdata = {w_rthr, w_inc};
                n_height    = (r_height == HEIGHT_MAX) ? HEIGHT_MAX : r_height + 10'd1;
                n_aval      = 24'd0;
                if ({1'b0, w_inc} > w_thr_val) begin
                    w_list_we    = 1'b1;
                    w_list_wdata = '0;
                    n_nxt_cnt    = r_nxt_cnt + 8'd1;
                    n_state      = ST_GEN;
                end else begin
                    n_state = ST_DRV_END;
                end
            end
            ST_GEN: begin
                n_bank    = ~r_bank;
                n_cur_cnt = r_nxt_cnt;
                n_nxt_cnt = 8'd0;
                n_i       = 8'd0;
                n_state   = (r_nxt_cnt == 8'd0) ? ST_DRV_END : ST_L_RD;
            end
            ST_L_RD: begin
                n_state = ST_P_RD;
            end
            ST_P_RD: begin
                if (LW'(w_lp) >= w_len) begin
                    n_i     = r_i + 8'd1;
                    n_state = (r_i + 8'd1 == r_cur_cnt) ? ST_GEN : ST_L_RD;
                end else begin
                    w_mem_raddr = w_lp;
                    n_p         = w_lp;
                    n_state     = ST_P_WR;
                end
            end
            ST_P_WR: begin
                if ({1'b0, w_rslope} <= w_thr_val) begin
                    n_i     = r_i + 8'd1;
                    n_state = (r_i + 8'd1 == r_cur_cnt) ? ST_GEN : ST_L_RD;
                end else begin
                    n_aval      = (r_aval == AVAL_MAX) ? AVAL_MAX : r_aval + 24'd1;
                    n_rng       = w_rng_next;
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_p;
                    w_mem_wdata = {w_draw, w_new_s};
                    if (({1'b0, w_new_s} == {3'd0, w_draw} + 4'd2) && (r_nxt_cnt < LIST_DEPTH)) begin
                        w_list_we    = 1'b1;
                        w_list_wdata = r_p;
                        n_nxt_cnt    = r_nxt_cnt + 8'd1;
                    end
                    if (r_p == '0) begin
                        if (r_height != 10'd0) begin
                            n_height = r_height - 10'd1;
                        end
                        n_nb  = SW'(1);
                        n_two = 1'b0;
                    end else if (w_p_last) begin
                        if (!r_flag) begin
                            n_cross = r_drive;
                            n_flag  = 1'b1;
                        end
                        n_nb  = r_p - SW'(1);
                        n_two = 1'b0;
                    end else begin
                        n_nb  = r_p - SW'(1);
                        n_two = 1'b1;
                    end
                    n_state = ST_N_RD;
                end
            end
            ST_N_RD: begin
                w_mem_raddr = r_nb;
                n_state     = ST_N_WR;
            end
            ST_N_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_nb;
                w_mem_wdata = {w_rthr, w_inc};
                if (({1'b0, w_inc} == w_thr_val + 4'd1) && (r_nxt_cnt < LIST_DEPTH)) begin
                    w_list_we    = 1'b1;
                    w_list_wdata = r_nb;
                    n_nxt_cnt    = r_nxt_cnt + 8'd1;
                end
                if (r_two) begin
                    n_nb    = r_p + SW'(1);
                    n_two   = 1'b0;
                    n_state = ST_N_RD;
                end else begin
                    n_i     = r_i + 8'd1;
                    n_state = (r_i + 8'd1 == r_cur_cnt) ? ST_GEN : ST_L_RD;
                end
            end
            ST_DRV_END: begin
                n_drive = r_drive + 32'd1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_data.pile_height     = r_height;
                    n_out_data.avalanche_size  = r_aval;
                    n_out_data.crossover_drive = r_cross;
                    n_out_data.crossover_seen  = r_flag;
                    n_out_data.slope_value     = r_slope_out;
                    n_state                    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rar_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the rice-pile avalanche block and their binding
// depends on rar_pkg and ricepile_avalanche_relax

module rar_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input rar_pkg::t_out_req          o_out_data,
    input logic                       pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");

    // one request at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while previous one in work");

    // a request is never answered in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall && pready)
        else $error("reset did not clear the output side");

endmodule

bind ricepile_avalanche_relax rar_checker u_rar_checker (.*);
